### design/assert_macros.svh
// Assertion helpers used by the allocator back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("allocator assertion failed");
// Same-cycle implication checked at every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator implication failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`endif
`endif

### design/fpba_pkg.sv
package fpba_pkg;

   // Pool geometry
   localparam int NUM_BLOCKS    = 5;
   localparam int ADDR_WIDTH    = 16;
   localparam int SIZE_WIDTH    = 10;
   localparam int IDX_WIDTH     = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int BIDX_WIDTH    = 3;

   // Register map
   localparam int CFG_SIZE_REGS = 5;
   localparam int CFG_BLOCKS    = (NUM_BLOCKS < CFG_SIZE_REGS) ? NUM_BLOCKS : CFG_SIZE_REGS;
   localparam int NUM_REGS      = 2 + CFG_SIZE_REGS;
   localparam int CSR_IDX_W     = $clog2(NUM_REGS);
   localparam int CSR_ADDR_W    = CSR_IDX_W + 2;
   localparam int CSR_DATA_W    = 32;

   localparam logic [CSR_IDX_W-1:0] REG_FIT_POLICY   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_BASE_ADDRESS = CSR_IDX_W'(1);
   localparam int                   REG_BLOCK0_SIZE  = 2;

   // Fit policies
   localparam logic [1:0] POLICY_NEXT  = 2'd0;
   localparam logic [1:0] POLICY_BEST  = 2'd1;
   localparam logic [1:0] POLICY_WORST = 2'd2;

   // Opcodes
   localparam logic OP_POOL_RESET = 1'b0;
   localparam logic OP_ALLOCATE   = 1'b1;

   // Command queue between front and back
   localparam int QDEPTH  = 2;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   localparam logic [ADDR_WIDTH-1:0] BASE_DEFAULT = ADDR_WIDTH'(3000);

   typedef struct packed {
      logic                  opcode;
      logic [SIZE_WIDTH-1:0] request_size;
   } req_type;

   typedef struct packed {
      logic                  granted;
      logic [BIDX_WIDTH-1:0] block_index;
      logic [ADDR_WIDTH-1:0] start_address;
      logic [ADDR_WIDTH-1:0] end_address;
   } rsp_type;

   typedef struct packed {
      logic                  is_alloc;
      logic [SIZE_WIDTH-1:0] size;
   } cmd_type;

   typedef struct packed {
      logic [1:0]                             fit_policy;
      logic [ADDR_WIDTH-1:0]                  base_address;
      logic [NUM_BLOCKS-1:0][SIZE_WIDTH-1:0]  block_size;
   } cfg_type;

   // Reset size of each block; blocks past the register list stay empty
   function automatic logic [SIZE_WIDTH-1:0] size_default(input int k);
      logic [SIZE_WIDTH-1:0] v;
      unique case (k)
         0:       v = SIZE_WIDTH'(1);
         1:       v = SIZE_WIDTH'(100);
         2:       v = SIZE_WIDTH'(150);
         3:       v = SIZE_WIDTH'(50);
         4:       v = SIZE_WIDTH'(25);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

### design/fit_policy_block_allocator_unit.sv
// Block allocator with next, best and worst fit over a fixed pool.
// The back end pops a word only while idle and takes no new word until the last is committed;
// it walks one block per cycle over all blocks (load or fit scan), then commits once the
// output is free.
// Reset (synchronous, active high) restores the registers to their defaults and
// leaves the pool unloaded, so every allocation fails until a pool reset word.
module fit_policy_block_allocator_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  fpba_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output fpba_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [fpba_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [fpba_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [fpba_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);
   import fpba_pkg::*;

   cfg_type              cfg_ff;
   logic [CSR_IDX_W-1:0] reg_idx;
   logic                 reg_wr;
   logic                 f_push;
   cmd_type              f_cmd;
   logic                 q_full;
   logic                 q_pop;
   logic                 q_valid;
   cmd_type              q_cmd;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign reg_wr     = csr_psel && csr_penable && csr_pwrite;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fit_policy   <= POLICY_NEXT;
         cfg_ff.base_address <= BASE_DEFAULT;
         for (int k = 0; k < NUM_BLOCKS; k++) begin
            cfg_ff.block_size[k] <= size_default(k);
         end
      end else if (reg_wr) begin
         if (reg_idx == REG_FIT_POLICY) begin
            cfg_ff.fit_policy <= csr_pwdata[1:0];
         end
         if (reg_idx == REG_BASE_ADDRESS) begin
            cfg_ff.base_address <= ADDR_WIDTH'(csr_pwdata[15:0]);
         end
         for (int k = 0; k < CFG_BLOCKS; k++) begin
            if (reg_idx == CSR_IDX_W'(REG_BLOCK0_SIZE + k)) begin
               cfg_ff.block_size[k] <= SIZE_WIDTH'(csr_pwdata[9:0]);
            end
         end
      end
   end

   // Register read back
   always_comb begin
      csr_prdata = '0;
      priority if (reg_idx == REG_FIT_POLICY) begin
         csr_prdata = CSR_DATA_W'(cfg_ff.fit_policy);
      end else if (reg_idx == REG_BASE_ADDRESS) begin
         csr_prdata = CSR_DATA_W'(cfg_ff.base_address);
      end else begin
         for (int k = 0; k < CFG_BLOCKS; k++) begin
            if (reg_idx == CSR_IDX_W'(REG_BLOCK0_SIZE + k)) begin
               csr_prdata = CSR_DATA_W'(cfg_ff.block_size[k]);
            end
         end
      end
   end

   fpba_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .push      (f_push),
      .cmd       (f_cmd),
      .full      (q_full)
   );

   fpba_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_cmd  (f_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .pop_cmd   (q_cmd)
   );

   fpba_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### design/fpba_front.sv
module fpba_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  fpba_pkg::req_type req_data,
   output logic             push,
   output fpba_pkg::cmd_type cmd,
   input  logic             full
);
   import fpba_pkg::*;

   logic    valid_ff;
   cmd_type cmd_ff;
   cmd_type cmd_in;
   logic    take;

   // Classify the incoming word; pool resets carry no size
   always_comb begin
      cmd_in.is_alloc = (req_data.opcode == OP_ALLOCATE);
      cmd_in.size     = cmd_in.is_alloc ? req_data.request_size : '0;
   end

   assign push      = valid_ff && !full;
   assign req_stall = valid_ff && full;
   assign take      = req_valid && !req_stall;
   assign cmd       = cmd_ff;

   // Hold one classified word until the queue takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= 1'b1;
      end else if (push) begin
         valid_ff <= 1'b0;
      end
      if (take) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

### design/fpba_queue.sv
module fpba_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  fpba_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output fpba_pkg::cmd_type pop_cmd
);
   import fpba_pkg::*;

   cmd_type           mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;

   assign full      = (count_ff == QCNT_W'(QDEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_cmd   = mem_ff[rd_ptr_ff];

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // Store the pushed word
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### design/fpba_back.sv
module fpba_back (
   input  logic              clock,
   input  logic              reset,
   input  fpba_pkg::cfg_type cfg,
   input  logic              q_valid,
   input  fpba_pkg::cmd_type q_cmd,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fpba_pkg::rsp_type rsp_data
);
   import fpba_pkg::*;

   `include "assert_macros.svh"

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type             state_ff;
   cmd_type               cmd_ff;
   logic [IDX_WIDTH-1:0]  k_ff;
   logic                  found_ff;
   logic [IDX_WIDTH-1:0]  pick_ff;
   logic [SIZE_WIDTH-1:0] pick_size_ff;
   logic [ADDR_WIDTH-1:0] pick_addr_ff;
   logic [ADDR_WIDTH-1:0] addr_ff;
   logic [SIZE_WIDTH-1:0] rem_ff [NUM_BLOCKS];
   logic [ADDR_WIDTH-1:0] nxt_ff [NUM_BLOCKS];
   logic [IDX_WIDTH-1:0]  scan_start_ff;
   logic                  loaded_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   logic [SIZE_WIDTH-1:0] cur_rem;
   logic                  last_k;
   logic                  eligible;
   logic                  take;
   logic                  out_free;
   logic                  commit;
   logic [ADDR_WIDTH-1:0] end_addr;
   rsp_type               rsp_in;

   assign q_pop     = (state_ff == ST_IDLE) && q_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign cur_rem   = rem_ff[k_ff];
   assign last_k    = (k_ff == IDX_WIDTH'(NUM_BLOCKS - 1));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign commit    = (state_ff == ST_DONE) && out_free;
   assign end_addr  = pick_addr_ff + ADDR_WIDTH'(cmd_ff.size);

   // Examine the block under the scan counter
   always_comb begin
      eligible = loaded_ff && (cur_rem != '0) && (cur_rem >= cmd_ff.size) &&
                 (cfg.fit_policy != POLICY_NEXT || k_ff >= scan_start_ff) &&
                 (cfg.fit_policy == POLICY_NEXT || cfg.fit_policy == POLICY_BEST ||
                  cfg.fit_policy == POLICY_WORST);
      priority if (!found_ff) begin
         take = eligible;
      end else if (cfg.fit_policy == POLICY_BEST) begin
         take = eligible && (cur_rem < pick_size_ff);
      end else if (cfg.fit_policy == POLICY_WORST) begin
         take = eligible && (cur_rem > pick_size_ff);
      end else begin
         take = 1'b0;
      end
   end

   // Form the result word
   always_comb begin
      rsp_in.granted       = !cmd_ff.is_alloc || found_ff;
      rsp_in.block_index   = found_ff ? BIDX_WIDTH'(pick_ff) : '0;
      rsp_in.start_address = found_ff ? pick_addr_ff : '0;
      rsp_in.end_address   = found_ff ? end_addr : '0;
   end

   // Sequencer: pool load or fit scan, one block per cycle, then commit
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         loaded_ff     <= 1'b0;
         scan_start_ff <= '0;
         found_ff      <= 1'b0;
      end else begin
         // Raise the result word on commit, drop it once taken
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  cmd_ff   <= q_cmd;
                  k_ff     <= '0;
                  found_ff <= 1'b0;
                  addr_ff  <= cfg.base_address;
                  state_ff <= q_cmd.is_alloc ? ST_SCAN : ST_LOAD;
               end
            end
            ST_LOAD: begin
               rem_ff[k_ff] <= cfg.block_size[k_ff];
               nxt_ff[k_ff] <= addr_ff;
               addr_ff      <= addr_ff + ADDR_WIDTH'(cfg.block_size[k_ff]);
               if (last_k) begin
                  scan_start_ff <= '0;
                  loaded_ff     <= 1'b1;
                  state_ff      <= ST_DONE;
               end else begin
                  k_ff <= k_ff + 1'b1;
               end
            end
            ST_SCAN: begin
               if (take) begin
                  found_ff     <= 1'b1;
                  pick_ff      <= k_ff;
                  pick_size_ff <= cur_rem;
                  pick_addr_ff <= nxt_ff[k_ff];
               end
               if (last_k) begin
                  state_ff <= ST_DONE;
               end else begin
                  k_ff <= k_ff + 1'b1;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_ff       <= rsp_in;
                  state_ff     <= ST_IDLE;
                  if (cmd_ff.is_alloc && found_ff) begin
                     rem_ff[pick_ff] <= pick_size_ff - cmd_ff.size;
                     nxt_ff[pick_ff] <= end_addr + 1'b1;
                     if (cfg.fit_policy == POLICY_NEXT) begin
                        scan_start_ff <= pick_ff;
                     end
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // A committed pick always has room for the request
   `ASSERT_IMPLY(a_pick_fits, clock, reset,
      state_ff == ST_DONE && cmd_ff.is_alloc && found_ff, pick_size_ff >= cmd_ff.size)
   // Next fit never picks a block below the scan start
   `ASSERT_IMPLY(a_next_fit_order, clock, reset,
      state_ff == ST_DONE && found_ff && cfg.fit_policy == POLICY_NEXT, pick_ff >= scan_start_ff)
   // Nothing is granted from an unloaded pool
   `ASSERT_IMPLY(a_unloaded_fails, clock, reset, state_ff == ST_SCAN && !loaded_ff, !found_ff)

endmodule
